// File: hdl/csfm_pkg.sv
// shared types, constants and helpers for the caseless substring search
package csfm_pkg;

  localparam int NEEDLE_BYTES   = 16;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int LEN_BITS       = 5;
  localparam int OUT_POS_BITS   = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LENGTH = 2'd2;

  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5a;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic valid;
    logic last;
    logic saturated;
  } stage_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      c = b + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

// File: hdl/csfm_if.sv
// beat channels for haystack bytes and search results
interface csfm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csfm_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink (input valid, input found, input match_position, output ready);
endinterface

// File: hdl/csfm_window.sv
// input stage: case folding, byte window and per-haystack byte counter
module csfm_window #(
  parameter int MAX_NEEDLE    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  csfm_text_if.sink                    text,
  input  logic                         take,
  output csfm_pkg::stage_ctrl_t        ctrl,
  output logic [MAX_NEEDLE-1:0][7:0]   window,
  output logic [POSITION_BITS-1:0]     pos
);
  import csfm_pkg::*;

  logic                            accept;
  logic [POSITION_BITS-1:0]        bytes_seen;
  logic                            saturated_now;
  logic [MAX_NEEDLE-1:0][7:0]      window_next;

  assign text.ready    = !ctrl.valid || take;
  assign accept        = text.valid && text.ready;
  assign saturated_now = (bytes_seen == {POSITION_BITS{1'b1}});

  always_comb begin
    for (int i = MAX_NEEDLE - 1; i > 0; i--) begin
      window_next[i] = window[i-1];
    end
    window_next[0] = fold_byte(text.text_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
      bytes_seen <= '0;
    end else if (accept) begin
      ctrl.valid     <= 1'b1;
      ctrl.last      <= text.end_of_text;
      ctrl.saturated <= saturated_now;
      if (text.end_of_text) begin
        bytes_seen <= '0;
      end else if (!saturated_now) begin
        bytes_seen <= bytes_seen + 1'b1;
      end
    end else if (take) begin
      ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
      pos    <= bytes_seen;
    end
  end

endmodule

// File: hdl/csfm_match.sv
// window compare against the needle, first-match tracking and result register
module csfm_match #(
  parameter int MAX_NEEDLE    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csfm_pkg::stage_ctrl_t                ctrl,
  input  logic [MAX_NEEDLE-1:0][7:0]           window,
  input  logic [POSITION_BITS-1:0]             pos,
  input  logic [csfm_pkg::CFG_DATA_BITS-1:0]   needle_low,
  input  logic [csfm_pkg::CFG_DATA_BITS-1:0]   needle_high,
  input  logic [csfm_pkg::LEN_BITS-1:0]        needle_length,
  output logic                                 take,
  csfm_result_if.source                        result
);
  import csfm_pkg::*;

  localparam int SUM_BITS = ((POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS) + 1;

  logic [2*CFG_DATA_BITS-1:0]   needle_all;
  logic [MAX_NEEDLE-1:0][7:0]   needle;
  logic [LEN_BITS-1:0]          len;
  logic [MAX_NEEDLE:0]          match_by_len;
  logic                         window_match;
  logic [SUM_BITS-1:0]          pos_ext;
  logic [SUM_BITS-1:0]          len_ext;
  logic [SUM_BITS-1:0]          start;
  logic                         enough;
  logic                         hit;
  logic                         answered;
  logic                         out_valid;
  logic                         found;
  logic [OUT_POS_BITS-1:0]      match_position;

  assign needle_all = {needle_high, needle_low};

  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      needle[i] = fold_byte(needle_all[8*i +: 8]);
    end
  end

  assign len = (needle_length > LEN_BITS'(MAX_NEEDLE)) ? LEN_BITS'(MAX_NEEDLE) : needle_length;

  // one compare chain per possible needle length
  always_comb begin
    logic m;
    match_by_len[0] = 1'b1;
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      m = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window[l-1-i] != needle[i]) begin
          m = 1'b0;
        end
      end
      match_by_len[l] = m;
    end
  end

  always_comb begin
    window_match = 1'b0;
    for (int l = 0; l <= MAX_NEEDLE; l++) begin
      if (len == LEN_BITS'(l)) begin
        window_match = match_by_len[l];
      end
    end
  end

  assign pos_ext = SUM_BITS'(pos);
  assign len_ext = SUM_BITS'(len);
  assign enough  = (pos_ext + 1'b1) >= len_ext;
  // empty needle reports position zero
  assign start   = (len == '0) ? '0 : pos_ext + 1'b1 - len_ext;
  assign hit     = !answered && !ctrl.saturated && enough && window_match;

  assign take = ctrl.valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      answered  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= hit || (ctrl.last && !answered);
        if (ctrl.last) begin
          answered <= 1'b0;
        end else if (hit) begin
          answered <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found          <= hit;
      match_position <= hit ? start[OUT_POS_BITS-1:0] : '0;
    end
  end

  assign result.valid          = out_valid;
  assign result.found          = found;
  assign result.match_position = match_position;

  a_notfound_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_position == '0)
    else $error("not-found result with nonzero position");

  a_hit_sets_answered: assert property (@(posedge clk) disable iff (rst)
    take && hit && !ctrl.last |=> answered)
    else $error("match did not mark haystack answered");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    take && answered && !ctrl.last |=> !out_valid)
    else $error("second result for one haystack");

  a_miss_only_at_end: assert property (@(posedge clk) disable iff (rst)
    take && !hit && !ctrl.last |=> !out_valid)
    else $error("not-found result before end of haystack");

endmodule

// File: hdl/caseless_substring_first_match_core.sv
// top level of the caseless first-match substring search
//
// text channel: one haystack byte per beat, end_of_text marks the last byte.
// result channel: exactly one beat per haystack, found with the start index
// of the first occurrence, or found low with position zero on the last byte.
// needle registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while no haystack beat is in flight, as the
// block does not enforce it; index 0 and 1 hold needle bytes 0-7 and 8-15,
// index 2 the needle length (zero gives a match at position 0).
// each byte passes through the input register and then the result register
// around the parallel window compare; one byte per cycle is sustained while
// no pending result is stalled by the result sink.
// reset clears the needle, the byte counter and the match flag.
// when the result sink stalls, one more byte is held in the input register
// and then text.ready drops until the pending result is taken.
module caseless_substring_first_match_core #(
  parameter int MAX_NEEDLE    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  csfm_text_if.sink                            text,
  csfm_result_if.source                        result,
  input  logic                                 cfg_write,
  input  logic [csfm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csfm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import csfm_pkg::*;

  logic [CFG_DATA_BITS-1:0]      needle_low;
  logic [CFG_DATA_BITS-1:0]      needle_high;
  logic [LEN_BITS-1:0]           needle_length;
  stage_ctrl_t                   ctrl;
  logic [MAX_NEEDLE-1:0][7:0]    window;
  logic [POSITION_BITS-1:0]      pos;
  logic                          take;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEEDLE_LOW:    needle_low    <= cfg_data;
        REG_NEEDLE_HIGH:   needle_high   <= cfg_data;
        REG_NEEDLE_LENGTH: needle_length <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  csfm_window #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .take   (take),
    .ctrl   (ctrl),
    .window (window),
    .pos    (pos)
  );

  csfm_match #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .window        (window),
    .pos           (pos),
    .needle_low    (needle_low),
    .needle_high   (needle_high),
    .needle_length (needle_length),
    .take          (take),
    .result        (result)
  );

endmodule

// File: verif/tb_caseless_substring_first_match_core.sv
`timescale 1ns / 1ps
// testbench for the caseless first-match substring search core
module tb_caseless_substring_first_match_core;
  import csfm_pkg::*;

  localparam int RANDOM_ITEMS    = 1300;
  localparam int PHASE_ITEMS     = 100;
  localparam int SETTLE_CYCLES   = 4;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam logic [15:0] SEEN_MAX = 16'hffff;

  typedef struct packed {
    logic        found;
    logic [15:0] pos;
  } search_result_t;

  typedef struct packed {
    logic           typed;
    search_result_t value;
  } known_result_t;

  typedef struct packed {
    logic        is_write;
    logic [1:0]  idx;
    logic [63:0] data;
    logic [7:0]  char_code;
    logic        last;
    logic [4:0]  count;
    logic        typed;
    logic        found;
    logic [15:0] pos;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  csfm_text_if text_ch ();
  csfm_result_if result_ch ();

  caseless_substring_first_match_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // search state mirrored from the beats seen on the ports
  logic [63:0] pat_low;
  logic [63:0] pat_high;
  logic [4:0]  pat_len;
  logic [7:0]  window [NEEDLE_BYTES];
  logic [15:0] seen_count;
  logic        answered;

  search_result_t due_results [$];
  known_result_t  typed_results [$];
  logic [7:0]     hay [$];
  int failures = 0;
  int sent = 0;
  int results_taken = 0;
  int idle_cycles = 0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (l >= 8'h61 && l <= 8'h7a && $urandom_range(0, 1) == 1) begin
      return l - 8'h20;
    end
    return l;
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) begin
      return flip_case(8'h61 + 8'($urandom_range(0, 2)));
    end
    return 8'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic void clear_search();
    foreach (window[i]) window[i] = 8'h00;
    seen_count = '0;
    answered = 1'b0;
  endfunction

  function automatic void search_step(input logic [7:0] raw, input logic last,
                                      output bit emit, output search_result_t res);
    logic [127:0] needle;
    int len;
    int pos;
    int start;
    bit sat;
    bit hit;
    needle = {pat_high, pat_low};
    len = (pat_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(pat_len);
    pos = int'(seen_count);
    sat = (seen_count == SEEN_MAX);
    hit = 1'b0;
    start = 0;
    emit = 1'b0;
    res = '0;
    for (int i = NEEDLE_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = to_lower(raw);
    if (!sat) seen_count = seen_count + 16'd1;
    if (!answered && !sat) begin
      if (len == 0) begin
        hit = 1'b1;
      end else if (pos + 1 >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (window[len-1-i] != to_lower(needle[8*i +: 8])) hit = 1'b0;
        end
        start = pos + 1 - len;
      end
    end
    if (hit) begin
      emit = 1'b1;
      res.found = 1'b1;
      res.pos = 16'(start);
      answered = 1'b1;
    end else if (last && !answered) begin
      emit = 1'b1;
    end
    if (last) clear_search();
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [63:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t beat_row(input logic [7:0] c, input logic last,
                                         input logic [4:0] count);
    plan_row_t r;
    r = '0;
    r.char_code = c;
    r.last = last;
    r.count = count;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [7:0] c, input logic last,
                                          input logic found, input logic [15:0] pos);
    plan_row_t r;
    r = beat_row(c, last, 5'd1);
    r.typed = 1'b1;
    r.found = found;
    r.pos = pos;
    return r;
  endfunction

  // prediction, result checking and the idle count for the watchdog
  always @(posedge clk) begin
    bit emit;
    search_result_t r;
    search_result_t exp_r;
    known_result_t k;
    if (rst) begin
      pat_low = '0;
      pat_high = '0;
      pat_len = '0;
      clear_search();
      idle_cycles = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NEEDLE_LOW: begin
            pat_low = cfg_data;
          end
          REG_NEEDLE_HIGH: begin
            pat_high = cfg_data;
          end
          REG_NEEDLE_LENGTH: begin
            pat_len = cfg_data[LEN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_ch.valid && text_ch.ready) begin
        search_step(text_ch.text_byte, text_ch.end_of_text, emit, r);
        k = typed_results.pop_front();
        if (k.typed) begin
          due_results.push_back(k.value);
        end else if (emit) begin
          due_results.push_back(r);
        end
      end
      if (result_ch.valid && result_ch.ready) begin
        results_taken++;
        if (due_results.size() == 0) begin
          $error("unexpected result beat: found %0b match_position %0d",
                 result_ch.found, result_ch.match_position);
          failures++;
        end else begin
          exp_r = due_results.pop_front();
          if (result_ch.found !== exp_r.found) begin
            $error("found: expected %0b, got %0b", exp_r.found, result_ch.found);
            failures++;
          end
          if (result_ch.match_position !== exp_r.pos) begin
            $error("match_position: expected %0d, got %0d", exp_r.pos,
                   result_ch.match_position);
            failures++;
          end
        end
      end
      if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
          cfg_write) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // result sink with random stalls and one long hold once results flow
  initial begin
    int on_len;
    int off_len;
    bit held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      on_len = $urandom_range(1, 12);
      off_len = pick_gap();
      if (!held && results_taken >= 40 && text_ch.valid) begin
        off_len = LONG_HOLD;
        held = 1'b1;
      end
      result_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len > 0) begin
        result_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last, input known_result_t k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= c;
    text_ch.end_of_text <= last;
    typed_results.push_back(k);
    sent++;
    do @(posedge clk); while (!(text_ch.valid && text_ch.ready));
  endtask

  task automatic send_haystack();
    foreach (hay[i]) send_char(hay[i], i == hay.size() - 1, '0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] val);
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    plan_row_t plan [$];
    logic [127:0] pat;
    int len;
    int eff_len;
    int r;
    int n;
    int phase_start;
    int random_start;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.end_of_text <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      // empty needle after reset, later bytes of the haystack stay quiet
      known_row(8'h78, 1'b0, 1'b1, 16'd0),
      beat_row(8'hff, 1'b1, 5'd1),
      // needle "Ab" in "aAB": partial overlap must not be lost
      reg_row(REG_NEEDLE_LOW, 64'h6241),
      reg_row(REG_NEEDLE_LENGTH, 64'd2),
      beat_row(8'h61, 1'b0, 5'd1),
      beat_row(8'h41, 1'b0, 5'd1),
      known_row(8'h42, 1'b1, 1'b1, 16'd1),
      // zero byte in needle must not match window bytes from before the haystack
      reg_row(REG_NEEDLE_LOW, 64'h6200),
      known_row(8'h62, 1'b1, 1'b0, 16'd0),
      // all ones needle, length past the maximum, match on the last byte
      reg_row(REG_NEEDLE_LOW, '1),
      reg_row(REG_NEEDLE_HIGH, '1),
      reg_row(REG_NEEDLE_LENGTH, 64'd31),
      beat_row(8'hff, 1'b0, 5'd15),
      known_row(8'hff, 1'b1, 1'b1, 16'd0),
      // folding edges around the upper case range
      reg_row(REG_NEEDLE_LOW, 64'h5a),
      reg_row(REG_NEEDLE_HIGH, 64'h0),
      reg_row(REG_NEEDLE_LENGTH, 64'd1),
      beat_row(8'h40, 1'b0, 5'd1),
      beat_row(8'h5b, 1'b0, 5'd1),
      known_row(8'h7a, 1'b1, 1'b1, 16'd2)
    };
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        for (int k = 1; k <= int'(plan[i].count); k++) begin
          send_char(plan[i].char_code, plan[i].last && k == int'(plan[i].count),
                    {plan[i].typed && k == int'(plan[i].count), plan[i].found, plan[i].pos});
        end
      end
    end

    random_start = sent;
    while (sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = 0;
      end else if (r < 55) begin
        len = $urandom_range(1, 3);
      end else if (r < 85) begin
        len = $urandom_range(4, 8);
      end else if (r < 95) begin
        len = $urandom_range(9, 16);
      end else begin
        len = $urandom_range(17, 31);
      end
      eff_len = (len > NEEDLE_BYTES) ? NEEDLE_BYTES : len;
      for (int i = 0; i < NEEDLE_BYTES; i++) begin
        pat[8*i +: 8] = (i < eff_len) ? pick_char() : 8'($urandom);
      end
      write_reg(REG_NEEDLE_LOW, pat[63:0]);
      write_reg(REG_NEEDLE_HIGH, pat[127:64]);
      write_reg(REG_NEEDLE_LENGTH, 64'(len));
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        hay = {};
        r = $urandom_range(0, 99);
        if (r < 60) begin
          n = $urandom_range(0, 12);
          repeat (n) hay.push_back(pick_char());
          for (int i = 0; i < eff_len; i++) hay.push_back(flip_case(pat[8*i +: 8]));
          n = $urandom_range(0, 6);
          repeat (n) hay.push_back(pick_char());
          if (hay.size() == 0) hay.push_back(pick_char());
        end else if (r < 85) begin
          n = $urandom_range(1, 20);
          repeat (n) hay.push_back(pick_char());
        end else begin
          n = $urandom_range(1, 20);
          repeat (n) hay.push_back(8'($urandom));
        end
        send_haystack();
      end
    end

    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
